// ===== hdl/pbbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbbs_pkg: shared types and constants
// Command and result records that pass between the front end, the command
// queue and the back end of the packet serializer, plus slot codes.
// ----------------------------------------------------------------------------
package pbbs_pkg;

    // Kind of work handed from the front end to the back end.
    localparam logic CMD_STATUS = 1'b0;
    localparam logic CMD_ECHO   = 1'b1;

    // Depth of the command queue between the two halves.
    localparam int CMDQ_DEPTH = 2;

    // Reset value of the bit period register.
    localparam logic [7:0] BIT_PERIOD_RST = 8'd60;

    // Slot codes within one 12-slot byte frame.
    localparam logic [3:0] SLOT_START   = 4'd0;
    localparam logic [3:0] SLOT_STOP_ON = 4'd9;
    localparam logic [3:0] SLOT_OFF     = 4'd10;
    localparam logic [3:0] SLOT_LAST    = 4'd11;

    typedef struct packed {
        logic kind;
        logic light;
        logic sending;
    } t_cmd;

    typedef struct packed {
        logic       light;
        logic       sending;
        logic       echo_valid;
        logic [7:0] echo_byte;
        logic       echo_last;
    } t_result;

endpackage

// ===== hdl/pbbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbbs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pbbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/pbbs_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbbs_cmdq: short command queue
// Holds commands from the front end until the back end takes them.
// ----------------------------------------------------------------------------
module pbbs_cmdq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pbbs_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output pbbs_pkg::t_cmd o_data,
    output logic          o_empty
);
    import pbbs_pkg::*;

    localparam int PW = $clog2(CMDQ_DEPTH);
    localparam int CW = $clog2(CMDQ_DEPTH + 1);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          do_push, do_pop;

    assign o_full  = (r_cnt == CW'(CMDQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_wp + PW'(1);
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(CMDQ_DEPTH - 1)) ? '0 : r_rp + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ===== hdl/pbbs_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbbs_front: item intake, packet reception and slot transmitter
// Classifies each item as a received byte or a timer tick, updates the
// receive and transmit state, writes the packet store and queues a command.
// ----------------------------------------------------------------------------
module pbbs_front #(
    parameter int BUFFER_BYTES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [7:0]                      i_cfg_wdata,
    input  logic                            i_push,
    input  logic                            i_mode,
    input  logic [7:0]                      i_rx_byte,
    output logic                            o_full,
    output logic                            o_ram_we,
    output logic [$clog2(BUFFER_BYTES)-1:0] o_ram_waddr,
    output logic [7:0]                      o_ram_wdata,
    output logic [$clog2(BUFFER_BYTES)-1:0] o_ram_raddr,
    input  logic [7:0]                      i_ram_rdata,
    output logic                            o_cmd_push,
    output pbbs_pkg::t_cmd                  o_cmd,
    input  logic                            i_cmd_full,
    input  logic                            i_echo_done,
    output logic                            o_echo_pend
);
    import pbbs_pkg::*;

    localparam int         AW     = $clog2(BUFFER_BYTES);
    localparam logic [8:0] MAXLEN = 9'(BUFFER_BYTES - 1);

    localparam logic [1:0] ST_RUN = 2'd0;
    localparam logic [1:0] ST_RD  = 2'd1;
    localparam logic [1:0] ST_CAP = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [7:0]    r_bit_period, n_bit_period;
    logic [AW-1:0] r_len, n_len;
    logic [AW-1:0] r_widx, n_widx;
    logic          r_recv, n_recv;
    logic          r_send, n_send;
    logic [7:0]    r_tick, n_tick;
    logic [AW-1:0] r_byte, n_byte;
    logic [3:0]    r_slot, n_slot;
    logic          r_light, n_light;
    logic [7:0]    r_cur, n_cur;
    logic          r_echo_pend, n_echo_pend;

    logic          accept;
    logic          done;
    logic [AW-1:0] len_c;
    logic [AW-1:0] done_len;

    assign o_full      = (r_state != ST_RUN) || i_cmd_full || r_echo_pend;
    assign accept      = i_push && !o_full;
    assign o_ram_raddr = r_byte;
    assign o_echo_pend = r_echo_pend;
    assign len_c       = ({1'b0, i_rx_byte} > MAXLEN) ? AW'(BUFFER_BYTES - 1)
                                                      : i_rx_byte[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_bit_period = r_bit_period;
        n_len        = r_len;
        n_widx       = r_widx;
        n_recv       = r_recv;
        n_send       = r_send;
        n_tick       = r_tick;
        n_byte       = r_byte;
        n_slot       = r_slot;
        n_light      = r_light;
        n_cur        = r_cur;
        n_echo_pend  = r_echo_pend;
        o_ram_we     = 1'b0;
        o_ram_waddr  = r_widx;
        o_ram_wdata  = i_rx_byte;
        done         = 1'b0;
        done_len     = r_len;

        if (i_cfg_we) begin
            n_bit_period = i_cfg_wdata;
        end
        if (i_echo_done) begin
            n_echo_pend = 1'b0;
        end

        case (r_state)
            ST_RUN: begin
                if (accept && i_mode) begin
                    if (r_send) begin
                        n_tick = r_tick + 8'd1;
                        if (n_tick >= r_bit_period) begin
                            n_tick = '0;
                            case (r_slot)
                                SLOT_START, SLOT_STOP_ON: begin
                                    n_light = 1'b1;
                                    n_slot  = r_slot + 4'd1;
                                end
                                SLOT_OFF: begin
                                    n_light = 1'b0;
                                    n_slot  = r_slot + 4'd1;
                                end
                                SLOT_LAST: begin
                                    n_light = 1'b0;
                                    n_slot  = SLOT_START;
                                    if (r_byte == r_len) begin
                                        n_send = 1'b0;
                                        n_byte = '0;
                                    end else begin
                                        // Fetch the next byte of the packet.
                                        n_byte  = r_byte + AW'(1);
                                        n_state = ST_RD;
                                    end
                                end
                                default: begin
                                    n_light = r_cur[3'(r_slot - 4'd1)];
                                    n_slot  = r_slot + 4'd1;
                                end
                            endcase
                        end
                    end
                end else if (accept && !r_send) begin
                    o_ram_we = 1'b1;
                    if (!r_recv) begin
                        o_ram_waddr = '0;
                        o_ram_wdata = 8'(len_c);
                        n_len       = len_c;
                        n_widx      = AW'(1);
                        n_recv      = 1'b1;
                        done        = (len_c == '0);
                        done_len    = len_c;
                    end else begin
                        n_widx = r_widx + AW'(1);
                        done   = (r_widx == r_len);
                    end
                    if (done) begin
                        n_recv      = 1'b0;
                        n_send      = 1'b1;
                        n_tick      = '0;
                        n_byte      = '0;
                        n_slot      = SLOT_START;
                        n_widx      = '0;
                        n_cur       = 8'(done_len);
                        n_echo_pend = 1'b1;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_CAP;
            end
            ST_CAP: begin
                n_cur   = i_ram_rdata;
                n_state = ST_RUN;
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase

        o_cmd_push    = accept;
        o_cmd.kind    = done ? CMD_ECHO : CMD_STATUS;
        o_cmd.light   = n_light;
        o_cmd.sending = n_send;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_RUN;
            r_bit_period <= BIT_PERIOD_RST;
            r_len        <= '0;
            r_widx       <= '0;
            r_recv       <= 1'b0;
            r_send       <= 1'b0;
            r_tick       <= '0;
            r_byte       <= '0;
            r_slot       <= SLOT_START;
            r_light      <= 1'b0;
            r_echo_pend  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bit_period <= n_bit_period;
            r_len        <= n_len;
            r_widx       <= n_widx;
            r_recv       <= n_recv;
            r_send       <= n_send;
            r_tick       <= n_tick;
            r_byte       <= n_byte;
            r_slot       <= n_slot;
            r_light      <= n_light;
            r_echo_pend  <= n_echo_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

endmodule

// ===== hdl/pbbs_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbbs_back: result generator
// Turns queued commands into result items; an echo command walks the packet
// store one byte at a time into the output register.
// ----------------------------------------------------------------------------
module pbbs_back #(
    parameter int BUFFER_BYTES = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cmd_empty,
    input  pbbs_pkg::t_cmd                  i_cmd,
    output logic                            o_cmd_pop,
    output logic [$clog2(BUFFER_BYTES)-1:0] o_ram_raddr,
    input  logic [7:0]                      i_ram_rdata,
    output logic                            o_echo_done,
    output pbbs_pkg::t_result               o_result,
    output logic                            o_empty,
    input  logic                            i_pop
);
    import pbbs_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_len, n_len;
    logic          r_light, n_light;
    logic          r_send, n_send;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;

    logic          out_free;
    logic          load;
    logic [AW-1:0] eff_len;
    logic          last;

    assign out_free    = !r_out_valid || i_pop;
    assign o_empty     = !r_out_valid;
    assign o_result    = r_out;
    assign o_ram_raddr = r_idx;
    // The length is the first stored byte, so it is known once index 0 is read.
    assign eff_len     = (r_idx == '0) ? i_ram_rdata[AW-1:0] : r_len;
    assign last        = (r_idx == eff_len);

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_len       = r_len;
        n_light     = r_light;
        n_send      = r_send;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        o_echo_done = 1'b0;
        load        = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (!i_cmd_empty) begin
                    if (i_cmd.kind == CMD_STATUS) begin
                        if (out_free) begin
                            o_cmd_pop        = 1'b1;
                            load             = 1'b1;
                            n_out.light      = i_cmd.light;
                            n_out.sending    = i_cmd.sending;
                            n_out.echo_valid = 1'b0;
                            n_out.echo_byte  = '0;
                            n_out.echo_last  = 1'b1;
                        end
                    end else begin
                        o_cmd_pop = 1'b1;
                        n_light   = i_cmd.light;
                        n_send    = i_cmd.sending;
                        n_idx     = '0;
                        n_state   = ST_RD;
                    end
                end
            end
            ST_RD: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    load             = 1'b1;
                    n_out.light      = r_light;
                    n_out.sending    = r_send;
                    n_out.echo_valid = 1'b1;
                    n_out.echo_byte  = i_ram_rdata;
                    n_out.echo_last  = last;
                    n_len            = eff_len;
                    if (last) begin
                        o_echo_done = 1'b1;
                        n_state     = ST_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = ST_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_len       <= '0;
            r_light     <= 1'b0;
            r_send      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_len       <= n_len;
            r_light     <= n_light;
            r_send      <= n_send;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

endmodule

// ===== hdl/packet_buffered_bit_serializer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_buffered_bit_serializer_unit: length-prefixed packet light sender
// Collects a packet of received bytes and sends it as 12-slot frames on a
// one-bit light output, echoing the whole packet when it completes.
// ----------------------------------------------------------------------------
// Each input item is either a received byte (mode 0) or a timer tick
// (mode 1). The first byte of a packet is its length, clamped to
// BUFFER_BYTES-1, and that many payload bytes follow. When the packet is
// complete, the block returns one result item per stored byte, length byte
// first, with echo_last on the final one, and starts sending. Every other
// item returns exactly one status item that carries the light level and the
// sending flag after that item. While sending, every bit_period ticks emit
// one slot of the current byte's frame: on, eight data bits LSB first, on,
// off, off. Received bytes are ignored while sending, and ticks are ignored
// while idle. Input is normally taken without holding off the next item. A
// tick that ends a byte frame holds off input while the next byte is fetched
// from the packet store through its single registered read port. A byte that
// completes a packet holds off input until the echo run has been read out of
// that same port, one stored byte at a time, and longer if the result side is
// not popping. A two-entry command queue between the intake and the result
// generator lets items keep flowing while results wait to be popped. The
// bit_period register is to be written through i_cfg_we/i_cfg_wdata only
// while the block is idle, which the user must keep to, since the block
// itself does not enforce it; a value of zero acts like one.
// ----------------------------------------------------------------------------
module packet_buffered_bit_serializer_unit #(
    parameter int BUFFER_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       push,
    output logic       full,
    input  logic       i_mode,
    input  logic [7:0] i_rx_byte,
    output logic       empty,
    input  logic       pop,
    output logic       o_light_level,
    output logic       o_sending,
    output logic       o_echo_valid,
    output logic [7:0] o_echo_byte,
    output logic       o_echo_last
);
    import pbbs_pkg::*;

    localparam int AW = $clog2(BUFFER_BYTES);

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [AW-1:0] front_raddr;
    logic [AW-1:0] back_raddr;
    logic [7:0]    ram_rdata;

    logic          cmd_push;
    t_cmd          cmd_in;
    logic          cmd_full;
    logic          cmd_pop;
    t_cmd          cmd_out;
    logic          cmd_empty;

    logic          echo_done;
    logic          echo_pend;
    t_result       result;

    // The intake is held off during an echo run, so the result generator
    // owns the read port for that whole time.
    assign ram_raddr = echo_pend ? back_raddr : front_raddr;

    pbbs_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    pbbs_front #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_mode      (i_mode),
        .i_rx_byte   (i_rx_byte),
        .o_full      (full),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (front_raddr),
        .i_ram_rdata (ram_rdata),
        .o_cmd_push  (cmd_push),
        .o_cmd       (cmd_in),
        .i_cmd_full  (cmd_full),
        .i_echo_done (echo_done),
        .o_echo_pend (echo_pend)
    );

    pbbs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    pbbs_back #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .o_ram_raddr (back_raddr),
        .i_ram_rdata (ram_rdata),
        .o_echo_done (echo_done),
        .o_result    (result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_light_level = result.light;
    assign o_sending     = result.sending;
    assign o_echo_valid  = result.echo_valid;
    assign o_echo_byte   = result.echo_byte;
    assign o_echo_last   = result.echo_last;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the packet buffered bit serializer
// Sends length-prefixed packets, timer ticks and stray bytes through the
// input queue and checks every result item against an in-bench prediction.
// ----------------------------------------------------------------------------
// The bench keeps its own copy of the serializer state: the packet store,
// the receive and send flags, the tick divider and the slot position within
// the current byte frame. Every item accepted on the input side is run
// through that prediction, which appends the result items it should produce
// to a queue. A separate process pops result items from the block and
// compares them field by field with the oldest queued prediction.
//
// Both sides may pause before each item, with some stretches where they
// never pause. One test holds the result side off for a long stretch
// so the block fills and stalls its input. The bit period is only written
// once nothing is in flight; some tests change it in the middle of a packet
// to keep the number of ticks down.
// ----------------------------------------------------------------------------
module tb_top;
    import pbbs_pkg::*;

    // Item kinds on the mode field.
    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam int PKT_BYTES     = 16;
    // A completed packet holds input while each stored byte is read out for the echo.
    localparam int DRAIN_CYCLES  = 2 * PKT_BYTES + 8;
    // Longest stretch without any handshake before the run is declared hung.
    localparam int QUIET_LIMIT   = 2000;
    // Number of input items the whole run aims for.
    localparam int ITEM_TARGET   = 420;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;
    logic       push;
    logic       full;
    logic       i_mode;
    logic [7:0] i_rx_byte;
    logic       empty;
    logic       pop;
    logic       o_light_level;
    logic       o_sending;
    logic       o_echo_valid;
    logic [7:0] o_echo_byte;
    logic       o_echo_last;

    packet_buffered_bit_serializer_unit #(
        .BUFFER_BYTES(PKT_BYTES)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .push          (push),
        .full          (full),
        .i_mode        (i_mode),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_light_level (o_light_level),
        .o_sending     (o_sending),
        .o_echo_valid  (o_echo_valid),
        .o_echo_byte   (o_echo_byte),
        .o_echo_last   (o_echo_last)
    );

    // ------------------------------------------------------------------------
    // Predicted serializer state
    // ------------------------------------------------------------------------
    logic [7:0] pkt_store [PKT_BYTES];
    int         fill_pos;
    logic       collecting;
    logic       transmitting;
    logic [7:0] tick_div;
    int         frame_byte;
    logic [3:0] frame_slot;
    logic       light_on;
    logic [7:0] period_setting;

    // Result items still owed by the block, oldest first.
    t_result    owed_results [$];

    int  error_count;
    int  items_sent;
    bit  sender_gaps;
    bit  receiver_gaps;
    int  hold_cycles;

    // Advances the frame by one slot. The second off slot also moves on to
    // the next stored byte, and past the last byte the packet is done.
    function automatic void advance_slot();
        logic [7:0] cur;
        cur = pkt_store[frame_byte];
        if (frame_slot == SLOT_START || frame_slot == SLOT_STOP_ON) begin
            light_on = 1'b1;
        end else if (frame_slot == SLOT_OFF) begin
            light_on = 1'b0;
        end else if (frame_slot >= SLOT_LAST) begin
            light_on   = 1'b0;
            frame_slot = SLOT_START;
            frame_byte++;
            if (frame_byte > int'(pkt_store[0])) begin
                transmitting = 1'b0;
                frame_byte   = 0;
            end
            return;
        end else begin
            light_on = cur[frame_slot - 1];
        end
        frame_slot++;
    endfunction

    // Runs one accepted item through the predicted state and queues the
    // result items it produces: the whole packet when it completes one,
    // otherwise a single status item.
    function automatic void predict_item(input logic mode, input logic [7:0] data);
        bit      completes;
        t_result res;
        completes = 1'b0;
        if (mode == MODE_TICK) begin
            if (transmitting) begin
                tick_div = tick_div + 8'd1;
                // A period of zero compares true on every tick, like one.
                if (tick_div >= period_setting) begin
                    tick_div = 8'd0;
                    advance_slot();
                end
            end
        end else if (!transmitting) begin
            if (!collecting) begin
                pkt_store[0] = (data > PKT_BYTES - 1) ? 8'(PKT_BYTES - 1) : data;
                fill_pos     = 1;
                collecting   = 1'b1;
            end else begin
                if (fill_pos < PKT_BYTES)
                    pkt_store[fill_pos] = data;
                fill_pos++;
            end
            if (fill_pos > int'(pkt_store[0])) begin
                collecting   = 1'b0;
                transmitting = 1'b1;
                tick_div     = 8'd0;
                frame_byte   = 0;
                frame_slot   = SLOT_START;
                fill_pos     = 0;
                completes    = 1'b1;
            end
        end

        res.light   = light_on;
        res.sending = transmitting;
        if (completes) begin
            for (int k = 0; k <= int'(pkt_store[0]); k++) begin
                res.echo_valid = 1'b1;
                res.echo_byte  = pkt_store[k];
                res.echo_last  = (k == int'(pkt_store[0]));
                owed_results.push_back(res);
            end
        end else begin
            res.echo_valid = 1'b0;
            res.echo_byte  = 8'd0;
            res.echo_last  = 1'b1;
            owed_results.push_back(res);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Clock, result side and checking
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t: %s is %0h, predicted %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // Compares every popped result item with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (pop && !empty) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result item with nothing predicted, echo_byte",
                                o_echo_byte, 0);
            end else begin
                want = owed_results.pop_front();
                if (o_light_level !== want.light)
                    report_mismatch("light_level", o_light_level, want.light);
                if (o_sending !== want.sending)
                    report_mismatch("sending", o_sending, want.sending);
                if (o_echo_valid !== want.echo_valid)
                    report_mismatch("echo_valid", o_echo_valid, want.echo_valid);
                if (o_echo_byte !== want.echo_byte)
                    report_mismatch("echo_byte", o_echo_byte, want.echo_byte);
                if (o_echo_last !== want.echo_last)
                    report_mismatch("echo_last", o_echo_last, want.echo_last);
            end
        end
    end

    // The receiver pauses a random number of cycles before each item. A long
    // hold requested by a test is added to the next pause, so pop is only
    // ever lowered and raised on different edges.
    initial begin
        int pause;
        pop = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            pause = receiver_gaps ? $urandom_range(0, 4) : 0;
            pause += hold_cycles;
            hold_cycles = 0;
            if (pause > 0) begin
                pop <= 1'b0;
                repeat (pause) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (!(pop && !empty));
            @(negedge i_clk);
        end
    end

    // Ends the run if no item moves on either side for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one item after a random pause and returns on the falling edge
    // after it was accepted.
    task automatic send_item(input logic mode, input logic [7:0] data);
        int pause;
        pause = sender_gaps ? $urandom_range(0, 4) : 0;
        if (pause > 0) begin
            push <= 1'b0;
            repeat (pause) @(negedge i_clk);
        end
        push      <= 1'b1;
        i_mode    <= mode;
        i_rx_byte <= data;
        do @(posedge i_clk); while (!(push && !full));
        predict_item(mode, data);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Stops offering items until every predicted result has come, then lets
    // the block finish any internal work.
    task automatic wait_until_drained();
        push <= 1'b0;
        while (owed_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_bit_period(input logic [7:0] value);
        wait_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we       <= 1'b0;
        period_setting  = value;
    endtask

    // Sends a length byte and as many payload bytes as the clamped length
    // asks for, with the odd tick mixed in while the packet is collected.
    task automatic send_packet(input logic [7:0] len_byte, input int noise_pct);
        int n;
        n = (len_byte > PKT_BYTES - 1) ? PKT_BYTES - 1 : len_byte;
        send_item(MODE_BYTE, len_byte);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(MODE_TICK, 8'($urandom_range(0, 255)));
            send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
    endtask

    // Ticks until the packet has gone out. Stray bytes sent meanwhile must
    // be ignored by the block.
    task automatic finish_packet(input int noise_pct);
        while (transmitting) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
            else
                send_item(MODE_TICK, 8'($urandom_range(0, 255)));
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Ticks while idle leave the light off and nothing sending.
    task automatic test_idle_ticks();
        send_item(MODE_TICK, 8'hFF);
        send_item(MODE_TICK, 8'h00);
    endtask

    // A zero length byte completes a packet at once, and a byte that arrives
    // while sending is ignored. The first slot needs the reset period worth
    // of ticks; the rest of the frame then goes out at one tick per slot.
    task automatic test_zero_length();
        send_item(MODE_BYTE, 8'h00);
        send_item(MODE_BYTE, 8'hAA);
        repeat (int'(BIT_PERIOD_RST)) send_item(MODE_TICK, 8'h55);
        write_bit_period(8'd1);
        finish_packet(0);
    endtask

    // The largest length byte is clamped, so fifteen payload bytes follow
    // and sixteen bytes are echoed. A bit period of zero sends them at one
    // slot per tick.
    task automatic test_max_length();
        write_bit_period(8'd0);
        send_item(MODE_BYTE, 8'hFF);
        for (int k = 0; k < PKT_BYTES - 1; k++) begin
            if (k == 0)
                send_item(MODE_BYTE, 8'h00);
            else if (k == 1)
                send_item(MODE_BYTE, 8'hFF);
            else
                send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        end
        finish_packet(0);
    endtask

    // The longest bit period holds the first slot back for many ticks.
    // Lowering the period below the count already reached then emits a slot
    // on the very next tick.
    task automatic test_max_period();
        write_bit_period(8'd255);
        send_item(MODE_BYTE, 8'h00);
        repeat (20) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
        write_bit_period(8'd1);
        finish_packet(0);
    endtask

    // The receiver stops popping for a long stretch while items keep coming,
    // so the block fills and holds off its input. Afterwards the sender
    // waits until every predicted result has been popped.
    task automatic test_full_stall();
        write_bit_period(8'd1);
        hold_cycles = 150;
        send_packet(8'd1, 0);
        for (int k = 0; k < 20; k++)
            send_item(MODE_TICK, 8'($urandom_range(0, 255)));
        finish_packet(0);
        wait_until_drained();
    endtask

    // Well-formed short packets with random content, each ticked out
    // completely, with ticks and stray bytes mixed in.
    task automatic test_random_traffic(input logic [7:0] period, input int n_items);
        int         first;
        logic [7:0] len_byte;
        write_bit_period(period);
        first = items_sent;
        while (items_sent - first < n_items) begin
            // Pick paced or back-to-back stretches at random per packet.
            sender_gaps   = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            len_byte = 8'($urandom_range(0, 3));
            if ($urandom_range(0, 9) == 0)
                send_item(MODE_TICK, 8'($urandom_range(0, 255)));
            send_packet(len_byte, 10);
            finish_packet(10);
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 8'd0;
        push          = 1'b0;
        i_mode        = MODE_BYTE;
        i_rx_byte     = 8'd0;
        error_count   = 0;
        items_sent    = 0;
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
        hold_cycles   = 0;

        // Predicted reset state. The store contents are never read before
        // a packet writes them.
        for (int k = 0; k < PKT_BYTES; k++)
            pkt_store[k] = 8'd0;
        fill_pos       = 0;
        collecting     = 1'b0;
        transmitting   = 1'b0;
        tick_div       = 8'd0;
        frame_byte     = 0;
        frame_slot     = SLOT_START;
        light_on       = 1'b0;
        period_setting = BIT_PERIOD_RST;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_idle_ticks();
        test_zero_length();
        test_max_length();
        test_max_period();
        test_full_stall();
        test_random_traffic(8'd1, (ITEM_TARGET - items_sent) / 2);
        test_random_traffic(8'd2, ITEM_TARGET - items_sent);

        wait_until_drained();
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
